### hdl/tac_pkg.sv
// ----------------------------------------------------------------------------
// tac_pkg: shared types and constants of the tilt angle block
// Widths of the normalised sample, square-root and CORDIC datapaths, the
// arctangent table in degrees and the rounding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tac_pkg;

  // format of the samples and of the angles
  localparam int SAMPLE_BITS     = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int FIELD_W         = 16;

  // normalised sample: largest magnitude brought to at least 2^NORM_MSB
  localparam int NORM_MSB = 22;
  localparam int NORM_W   = NORM_MSB + 2;
  localparam int SH_W     = $clog2(NORM_W);

  // sums of squares and their square roots
  localparam int SQ_W   = 2 * NORM_W;
  localparam int ROOT_W = (SQ_W + 16) / 2;
  localparam int REM_W  = ROOT_W + 4;

  // three lanes: x-tilt, y-tilt, vertical
  localparam int LANES = 3;

  // cordic datapath
  localparam int INT_FRAC     = 16;
  localparam int CORDIC_STEPS = 23;
  localparam int CW           = ROOT_W + 4;
  localparam int ANG_W        = 26;
  localparam int ROUND_SH     = INT_FRAC - ANGLE_FRAC_BITS;

  typedef logic signed [NORM_W-1:0] norm_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [ROOT_W-1:0]        root_t;
  typedef logic signed [ANG_W-1:0]  ang_t;

  // control that travels alongside each item
  typedef struct packed {
    logic vld;
    logic zero;
  } flags_t;

  localparam ang_t NINETY_INT = ang_t'(90) <<< INT_FRAC;
  localparam ang_t NINETY_OUT = ang_t'(90) <<< ANGLE_FRAC_BITS;
  localparam ang_t ROUND_HALF = ang_t'(1) <<< (ROUND_SH - 1);

  // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
  function automatic ang_t atan_entry(input int idx);
    ang_t v;
    case (idx)
      0:  v = ang_t'(2949120);
      1:  v = ang_t'(1740967);
      2:  v = ang_t'(919879);
      3:  v = ang_t'(466945);
      4:  v = ang_t'(234379);
      5:  v = ang_t'(117304);
      6:  v = ang_t'(58666);
      7:  v = ang_t'(29335);
      8:  v = ang_t'(14668);
      9:  v = ang_t'(7334);
      10: v = ang_t'(3667);
      11: v = ang_t'(1833);
      12: v = ang_t'(917);
      13: v = ang_t'(458);
      14: v = ang_t'(229);
      15: v = ang_t'(115);
      16: v = ang_t'(57);
      17: v = ang_t'(29);
      18: v = ang_t'(14);
      19: v = ang_t'(7);
      20: v = ang_t'(4);
      21: v = ang_t'(2);
      22: v = ang_t'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // round to the output step (ties upward) and clamp
  function automatic ang_t round_clamp(input ang_t a, input ang_t lo, input ang_t hi);
    ang_t r;
    r = (a + ROUND_HALF) >>> ROUND_SH;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/tac_norm.sv
// ----------------------------------------------------------------------------
// tac_norm: sample normalisation and sums of squares
// Three stages: shift the sample up to full scale, square each axis,
// form the three pairwise sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tac_norm (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire logic [tac_pkg::FIELD_W-1:0]     in_x,
  input  wire logic [tac_pkg::FIELD_W-1:0]     in_y,
  input  wire logic [tac_pkg::FIELD_W-1:0]     in_z,
  output tac_pkg::flags_t                      out_flg,
  output tac_pkg::norm_t                       out_num [tac_pkg::LANES],
  output tac_pkg::sq_t                         out_sum [tac_pkg::LANES]
);

  logic [tac_pkg::FIELD_W-1:0]       raw [tac_pkg::LANES];
  logic signed [tac_pkg::SAMPLE_BITS-1:0] smp [tac_pkg::LANES];
  logic [tac_pkg::SAMPLE_BITS-1:0]   mag [tac_pkg::LANES];
  logic [tac_pkg::SAMPLE_BITS-1:0]   mmax;
  logic [tac_pkg::SH_W-1:0]          hb;
  logic [tac_pkg::SH_W-1:0]          sh;
  tac_pkg::norm_t                    v_nxt [tac_pkg::LANES];
  logic signed [2*tac_pkg::NORM_W-1:0] prod [tac_pkg::LANES];

  logic                              vld1_r, vld2_r, vld3_r;
  logic                              zero1_r, zero2_r, zero3_r;
  tac_pkg::norm_t                    v1_r [tac_pkg::LANES];
  tac_pkg::norm_t                    v2_r [tac_pkg::LANES];
  tac_pkg::norm_t                    v3_r [tac_pkg::LANES];
  tac_pkg::sq_t                      sq2_r [tac_pkg::LANES];
  tac_pkg::sq_t                      sum3_r [tac_pkg::LANES];

  assign raw[0] = in_x;
  assign raw[1] = in_y;
  assign raw[2] = in_z;

  // largest magnitude, its top bit and the normalising shift
  always_comb begin
    mmax = '0;
    hb   = '0;
    for (int l = 0; l < tac_pkg::LANES; l++) begin
      smp[l] = signed'(raw[l][tac_pkg::SAMPLE_BITS-1:0]);
      mag[l] = smp[l][tac_pkg::SAMPLE_BITS-1] ? -raw[l][tac_pkg::SAMPLE_BITS-1:0]
                                              : raw[l][tac_pkg::SAMPLE_BITS-1:0];
      if (mag[l] > mmax) mmax = mag[l];
    end
    for (int j = 0; j < tac_pkg::SAMPLE_BITS; j++) begin
      if (mmax[j]) hb = tac_pkg::SH_W'(j);
    end
    if (hb < tac_pkg::SH_W'(tac_pkg::NORM_MSB)) sh = tac_pkg::SH_W'(tac_pkg::NORM_MSB) - hb;
    else sh = '0;
    for (int l = 0; l < tac_pkg::LANES; l++) begin
      v_nxt[l] = tac_pkg::norm_t'(smp[l]) <<< sh;
    end
  end

  // squares of the normalised axes
  always_comb begin
    for (int l = 0; l < tac_pkg::LANES; l++) begin
      prod[l] = v1_r[l] * v1_r[l];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      zero1_r <= (mmax == '0);
      zero2_r <= zero1_r;
      zero3_r <= zero2_r;
      for (int l = 0; l < tac_pkg::LANES; l++) begin
        v1_r[l]  <= v_nxt[l];
        v2_r[l]  <= v1_r[l];
        v3_r[l]  <= v2_r[l];
        sq2_r[l] <= tac_pkg::sq_t'(prod[l]);
      end
      sum3_r[0] <= sq2_r[1] + sq2_r[2];
      sum3_r[1] <= sq2_r[0] + sq2_r[2];
      sum3_r[2] <= sq2_r[0] + sq2_r[1];
    end
  end

  assign out_flg.vld  = vld3_r;
  assign out_flg.zero = zero3_r;
  assign out_num      = v3_r;
  assign out_sum      = sum3_r;

endmodule

`default_nettype wire

### hdl/tac_isqrt.sv
// ----------------------------------------------------------------------------
// tac_isqrt: pipelined integer square root, three lanes
// One root bit per stage; the radicand is the sum of squares scaled by 2^16,
// so the root carries 8 fractional bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tac_isqrt (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire tac_pkg::flags_t in_flg,
  input  wire tac_pkg::norm_t  in_num [tac_pkg::LANES],
  input  wire tac_pkg::sq_t    in_sum [tac_pkg::LANES],
  output tac_pkg::flags_t      out_flg,
  output tac_pkg::norm_t       out_num [tac_pkg::LANES],
  output tac_pkg::root_t       out_root [tac_pkg::LANES]
);

  localparam int NS = tac_pkg::ROOT_W;

  logic [tac_pkg::REM_W-1:0] rem_r  [NS][tac_pkg::LANES];
  tac_pkg::root_t            root_r [NS][tac_pkg::LANES];
  tac_pkg::sq_t              rad_r  [NS][tac_pkg::LANES];
  tac_pkg::norm_t            num_r  [NS][tac_pkg::LANES];
  logic                      vld_r  [NS];
  logic                      zero_r [NS];

  logic [tac_pkg::REM_W-1:0] rem_nxt  [NS][tac_pkg::LANES];
  tac_pkg::root_t            root_nxt [NS][tac_pkg::LANES];
  tac_pkg::sq_t              rad_nxt  [NS][tac_pkg::LANES];

  logic [tac_pkg::REM_W-1:0] rem_i, cur, trial;
  tac_pkg::root_t            root_i;
  tac_pkg::sq_t              rad_i;

  // one digit of the square-root recurrence in every stage
  always_comb begin
    for (int st = 0; st < NS; st++) begin
      for (int l = 0; l < tac_pkg::LANES; l++) begin
        if (st == 0) begin
          rem_i  = '0;
          root_i = '0;
          rad_i  = in_sum[l];
        end else begin
          rem_i  = rem_r[st-1][l];
          root_i = root_r[st-1][l];
          rad_i  = rad_r[st-1][l];
        end
        cur   = {rem_i[tac_pkg::REM_W-3:0], rad_i[tac_pkg::SQ_W-1:tac_pkg::SQ_W-2]};
        trial = tac_pkg::REM_W'({root_i, 2'b01});
        if (cur >= trial) begin
          rem_nxt[st][l]  = cur - trial;
          root_nxt[st][l] = {root_i[tac_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt[st][l]  = cur;
          root_nxt[st][l] = {root_i[tac_pkg::ROOT_W-2:0], 1'b0};
        end
        rad_nxt[st][l] = rad_i << 2;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int st = 0; st < NS; st++) vld_r[st] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_flg.vld;
      for (int st = 1; st < NS; st++) vld_r[st] <= vld_r[st-1];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= in_flg.zero;
      for (int st = 1; st < NS; st++) zero_r[st] <= zero_r[st-1];
      for (int st = 0; st < NS; st++) begin
        for (int l = 0; l < tac_pkg::LANES; l++) begin
          rem_r[st][l]  <= rem_nxt[st][l];
          root_r[st][l] <= root_nxt[st][l];
          rad_r[st][l]  <= rad_nxt[st][l];
          num_r[st][l]  <= (st == 0) ? in_num[l] : num_r[st-1][l];
        end
      end
    end
  end

  assign out_flg.vld  = vld_r[NS-1];
  assign out_flg.zero = zero_r[NS-1];
  assign out_num      = num_r[NS-1];
  assign out_root     = root_r[NS-1];

endmodule

`default_nettype wire

### hdl/tac_cordic.sv
// ----------------------------------------------------------------------------
// tac_cordic: pipelined vectoring cordic, three lanes
// One micro-rotation per stage gives atan2(num, den) in degrees with
// 16 fractional bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tac_cordic (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire tac_pkg::flags_t in_flg,
  input  wire tac_pkg::norm_t  in_num [tac_pkg::LANES],
  input  wire tac_pkg::root_t  in_den [tac_pkg::LANES],
  output tac_pkg::flags_t      out_flg,
  output tac_pkg::ang_t        out_ang [tac_pkg::LANES]
);

  localparam int NS = tac_pkg::CORDIC_STEPS;

  typedef logic signed [tac_pkg::CW-1:0] cw_t;

  cw_t            px_r  [NS][tac_pkg::LANES];
  cw_t            py_r  [NS][tac_pkg::LANES];
  tac_pkg::ang_t  ang_r [NS][tac_pkg::LANES];
  logic           vld_r [NS];
  logic           zero_r[NS];

  cw_t            px_nxt  [NS][tac_pkg::LANES];
  cw_t            py_nxt  [NS][tac_pkg::LANES];
  tac_pkg::ang_t  ang_nxt [NS][tac_pkg::LANES];

  cw_t            px_i, py_i, dx, dy;
  tac_pkg::ang_t  ang_i;

  // one rotation per stage, downward while y is zero or positive
  always_comb begin
    for (int st = 0; st < NS; st++) begin
      for (int l = 0; l < tac_pkg::LANES; l++) begin
        if (st == 0) begin
          px_i  = cw_t'({1'b0, in_den[l]});
          py_i  = cw_t'(in_num[l]) <<< 8;
          ang_i = '0;
        end else begin
          px_i  = px_r[st-1][l];
          py_i  = py_r[st-1][l];
          ang_i = ang_r[st-1][l];
        end
        dx = py_i >>> st;
        dy = px_i >>> st;
        if (!py_i[tac_pkg::CW-1]) begin
          px_nxt[st][l]  = px_i + dx;
          py_nxt[st][l]  = py_i - dy;
          ang_nxt[st][l] = ang_i + tac_pkg::atan_entry(st);
        end else begin
          px_nxt[st][l]  = px_i - dx;
          py_nxt[st][l]  = py_i + dy;
          ang_nxt[st][l] = ang_i - tac_pkg::atan_entry(st);
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int st = 0; st < NS; st++) vld_r[st] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_flg.vld;
      for (int st = 1; st < NS; st++) vld_r[st] <= vld_r[st-1];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= in_flg.zero;
      for (int st = 1; st < NS; st++) zero_r[st] <= zero_r[st-1];
      for (int st = 0; st < NS; st++) begin
        for (int l = 0; l < tac_pkg::LANES; l++) begin
          px_r[st][l]  <= px_nxt[st][l];
          py_r[st][l]  <= py_nxt[st][l];
          ang_r[st][l] <= ang_nxt[st][l];
        end
      end
    end
  end

  assign out_flg.vld  = vld_r[NS-1];
  assign out_flg.zero = zero_r[NS-1];
  assign out_ang      = ang_r[NS-1];

endmodule

`default_nettype wire

### hdl/accel_tilt_angle_limit_check.sv
// ----------------------------------------------------------------------------
// accel_tilt_angle_limit_check: tilt angles of a three-axis sample
// Takes one sample per cycle unless stalled and returns x-tilt, y-tilt and
// the angle from vertical in degrees with 8 fractional bits, plus a flag
// that is set when no angle magnitude exceeds cfg limit. The stages run in
// order through normalisation and squares, the bit-per-stage square root,
// the cordic rotations, then rounding and the output register. The
// whole pipeline advances together and holds only while a finished result
// waits at the output under stall, so throughput is one transfer per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_angle_limit_check (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [15:0]                 cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tac_pkg::FIELD_W-1:0] in_accel_x,
  input  wire logic [tac_pkg::FIELD_W-1:0] in_accel_y,
  input  wire logic [tac_pkg::FIELD_W-1:0] in_accel_z,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [tac_pkg::FIELD_W-1:0]      out_tilt_x_deg,
  output logic [tac_pkg::FIELD_W-1:0]      out_tilt_y_deg,
  output logic [tac_pkg::FIELD_W-1:0]      out_tilt_vertical_deg,
  output logic                             out_within_limit
);

  localparam logic [15:0] LIMIT_RESET = 16'd11520;

  logic              en;
  logic [15:0]       limit_r;

  tac_pkg::flags_t   nrm_flg, sqr_flg, cor_flg;
  tac_pkg::norm_t    nrm_num [tac_pkg::LANES];
  tac_pkg::sq_t      nrm_sum [tac_pkg::LANES];
  tac_pkg::norm_t    sqr_num [tac_pkg::LANES];
  tac_pkg::root_t    sqr_root[tac_pkg::LANES];
  tac_pkg::ang_t     cor_ang [tac_pkg::LANES];

  tac_pkg::ang_t     rnd_nxt [tac_pkg::LANES];
  tac_pkg::ang_t     rnd_r   [tac_pkg::LANES];
  logic              rnd_vld_r;
  tac_pkg::ang_t     lim, mag_x, mag_y;
  logic              ok_nxt;
  logic              out_valid_r;

  // whole pipeline moves unless a result waits under stall
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  tac_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_x     (in_accel_x),
    .in_y     (in_accel_y),
    .in_z     (in_accel_z),
    .out_flg  (nrm_flg),
    .out_num  (nrm_num),
    .out_sum  (nrm_sum)
  );

  tac_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_flg   (nrm_flg),
    .in_num   (nrm_num),
    .in_sum   (nrm_sum),
    .out_flg  (sqr_flg),
    .out_num  (sqr_num),
    .out_root (sqr_root)
  );

  tac_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_flg   (sqr_flg),
    .in_num   (sqr_num),
    .in_den   (sqr_root),
    .out_flg  (cor_flg),
    .out_ang  (cor_ang)
  );

  // rounding and clamping; the vertical angle is 90 degrees less atan2(z, r)
  always_comb begin
    rnd_nxt[0] = tac_pkg::round_clamp(cor_ang[0], -tac_pkg::NINETY_OUT, tac_pkg::NINETY_OUT);
    rnd_nxt[1] = tac_pkg::round_clamp(cor_ang[1], -tac_pkg::NINETY_OUT, tac_pkg::NINETY_OUT);
    rnd_nxt[2] = tac_pkg::round_clamp(tac_pkg::NINETY_INT - cor_ang[2], '0,
                                      tac_pkg::NINETY_OUT <<< 1);
    if (cor_flg.zero) begin
      for (int l = 0; l < tac_pkg::LANES; l++) rnd_nxt[l] = '0;
    end
  end

  // limit comparison on the rounded angles
  always_comb begin
    lim    = tac_pkg::ang_t'({1'b0, limit_r});
    mag_x  = rnd_r[0][tac_pkg::ANG_W-1] ? -rnd_r[0] : rnd_r[0];
    mag_y  = rnd_r[1][tac_pkg::ANG_W-1] ? -rnd_r[1] : rnd_r[1];
    ok_nxt = (mag_x <= lim) && (mag_y <= lim) && (rnd_r[2] <= lim);
  end

  // valid bits of the last two stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      rnd_vld_r   <= cor_flg.vld;
      out_valid_r <= rnd_vld_r;
    end
  end

  // rounded angles and output register
  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r                 <= rnd_nxt;
      out_tilt_x_deg        <= rnd_r[0][tac_pkg::FIELD_W-1:0];
      out_tilt_y_deg        <= rnd_r[1][tac_pkg::FIELD_W-1:0];
      out_tilt_vertical_deg <= rnd_r[2][tac_pkg::FIELD_W-1:0];
      out_within_limit      <= ok_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // tilts stay within plus or minus ninety degrees
  a_tilt_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_tilt_x_deg) <= 16'sd23040 &&
                     $signed(out_tilt_x_deg) >= -16'sd23040))
    else $error("x tilt out of range");

  a_tilt_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_tilt_y_deg) <= 16'sd23040 &&
                     $signed(out_tilt_y_deg) >= -16'sd23040))
    else $error("y tilt out of range");

  // nothing leaves the pipeline straight after reset
  a_flush_on_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule

`default_nettype wire
